// ----- rtl/ppr_pkg.sv -----
`default_nettype none

package ppr_pkg;

   localparam int VAL_W    = 48;
   localparam int SEQ_W    = 32;
   localparam int CAP_W    = 11;
   localparam int COUNT_W  = 11;
   localparam int AXES     = 3;
   localparam int AXIS_W   = 2;

   localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;
   localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1024;

   typedef logic [VAL_W-1:0] value_type;
   typedef logic [SEQ_W-1:0] seq_type;

   typedef enum logic {
      CMD_PUSH      = 1'b0,
      CMD_RECONCILE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_BAD_SEQ    = 3'd1,
      STAT_PUSH_OVF   = 3'd2,
      STAT_BAD_REC    = 3'd3,
      STAT_REPLAY_OVF = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_ADD,
      ST_PUSH_COMMIT,
      ST_REC_READ,
      ST_REC_CHECK,
      ST_REC_ADD,
      ST_REC_COMMIT,
      ST_RESP
   } state_type;

   // One buffered input: its sequence and the three axis deltas.
   typedef struct packed {
      seq_type               seq;
      value_type [AXES-1:0]  delta;
   } entry_type;

   typedef struct packed {
      value_type sum;
      logic      ovf;
   } add_result_type;

endpackage

`default_nettype wire

// ----- rtl/ppr_if.sv -----
`default_nettype none

interface ppr_req_if;
   import ppr_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   seq_type     seq_number;
   value_type   value_x;
   value_type   value_y;
   value_type   value_z;

   modport source (output valid, command, seq_number, value_x, value_y, value_z,
                   input ready);
   modport sink   (input valid, command, seq_number, value_x, value_y, value_z,
                   output ready);
endinterface

interface ppr_rsp_if;
   import ppr_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   value_type          pos_x;
   value_type          pos_y;
   value_type          pos_z;
   logic [COUNT_W-1:0] pending_count;

   modport source (output valid, status, pos_x, pos_y, pos_z, pending_count,
                   input ready);
   modport sink   (input valid, status, pos_x, pos_y, pos_z, pending_count,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/ppr_add_unit.sv -----
`default_nettype none

module ppr_add_unit (
   input  wire ppr_pkg::value_type      a,
   input  wire ppr_pkg::value_type      b,
   output ppr_pkg::add_result_type      result
);
   import ppr_pkg::*;

   logic [VAL_W:0] wide_sum;

   assign wide_sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};

   // The sum leaves the signed range when the two top bits disagree.
   assign result.sum = wide_sum[VAL_W-1:0];
   assign result.ovf = wide_sum[VAL_W] ^ wide_sum[VAL_W-1];

endmodule

`default_nettype wire

// ----- rtl/ppr_entry_mem.sv -----
`default_nettype none

module ppr_entry_mem #(
   parameter  int DEPTH = 1024,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire [IDX_W-1:0]            wr_addr,
   input  wire ppr_pkg::entry_type    wr_data,
   input  wire                        rd_en,
   input  wire [IDX_W-1:0]            rd_addr,
   output ppr_pkg::entry_type         rd_data
);
   import ppr_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so the sequencer may use it across its check and add steps.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/predicted_position_replay_buffer_core.sv -----
// Predicted position replay buffer. A push (command 0) appends a movement delta to a queue of
// up to min(capacity, BUFFER_DEPTH) entries and adds it to the predicted position; a reconcile
// (command 1) drops the acknowledged entries and replays the rest onto the authoritative
// position. All position arithmetic goes through one shared 48-bit adder, one axis per cycle,
// and the queue lives in a single-port-read memory with registered read data. One request is
// worked on at a time and the request side is ready only between requests. An accepted push
// passes the adder once per axis and commits before its response step; a push or reconcile
// that fails its checks goes straight to the response step, and a push whose sum overflows
// goes there from that axis's adder pass. A reconcile walks the queued entries in order and
// then commits; each entry costs one memory read and one check, and a replayed entry three
// more adder passes. A replay overflow ends the walk at that axis.
// The next request beat can be taken in the cycle the response is raised. A result that
// waits on rsp_if.ready holds only the following request, in its response step. Overflow or a
// rejected check leaves the queue, position and sequence records unchanged. The capacity
// register is written through csr_wr_en / csr_wr_data and resets to 1024.
`default_nettype none

module predicted_position_replay_buffer_core #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  wire                          clock,
   input  wire                          reset,
   ppr_req_if.sink                      req_if,
   ppr_rsp_if.source                    rsp_if,
   input  wire                          csr_wr_en,
   input  wire [ppr_pkg::CAP_W-1:0]     csr_wr_data
);
   import ppr_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int SUM_W = IDX_W + 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(BUFFER_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

   state_type           state_ff, state_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   seq_type             last_push_ff, last_push_in;
   seq_type             last_ack_ff, last_ack_in;
   value_type           pos_ff [AXES];
   value_type           pos_in [AXES];
   value_type           np_ff [AXES];
   value_type           np_in [AXES];
   value_type           val_ff [AXES];
   value_type           val_in [AXES];
   seq_type             seq_ff, seq_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    drop_ff, drop_in;
   status_type          status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   value_type           rsp_pos_ff [AXES];
   value_type           rsp_pos_in [AXES];
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   entry_type           mem_wr_data;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   entry_type           mem_rd_data;

   value_type           add_b;
   add_result_type      add_res;

   logic                req_fire;
   logic                queue_full;
   logic [CNT_W-1:0]    idx_next;

   function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= DEPTH_SUM) ? s - DEPTH_SUM : s;
      return r[IDX_W-1:0];
   endfunction

   ppr_entry_mem #(
      .DEPTH   (BUFFER_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Pushes add the latched request delta, replays add the delta read from the queue.
   assign add_b = (state_ff == ST_PUSH_ADD) ? val_ff[axis_ff] : mem_rd_data.delta[axis_ff];

   ppr_add_unit u_add (
      .a      (np_ff[axis_ff]),
      .b      (add_b),
      .result (add_res)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && (state_ff == ST_IDLE);
   assign queue_full   = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (count_ff == DEPTH_CNT);
   assign idx_next     = idx_ff + CNT_W'(1);

   assign mem_wr_data.seq      = seq_ff;
   assign mem_wr_data.delta[0] = val_ff[0];
   assign mem_wr_data.delta[1] = val_ff[1];
   assign mem_wr_data.delta[2] = val_ff[2];
   assign mem_wr_addr = wrap_slot(SUM_W'(head_ff) + SUM_W'(count_ff));
   assign mem_rd_addr = wrap_slot(SUM_W'(head_ff) + SUM_W'(idx_ff));

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      last_push_in  = last_push_ff;
      last_ack_in   = last_ack_ff;
      pos_in        = pos_ff;
      np_in         = np_ff;
      val_in        = val_ff;
      seq_in        = seq_ff;
      axis_in       = axis_ff;
      idx_in        = idx_ff;
      drop_in       = drop_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               seq_in    = req_if.seq_number;
               val_in[0] = req_if.value_x;
               val_in[1] = req_if.value_y;
               val_in[2] = req_if.value_z;
               axis_in   = '0;
               idx_in    = '0;
               drop_in   = '0;
               if (req_if.command == CMD_PUSH) begin
                  if (req_if.seq_number == '0 || req_if.seq_number <= last_push_ff ||
                      queue_full) begin
                     status_in = STAT_BAD_SEQ;
                     state_in  = ST_RESP;
                  end else begin
                     np_in    = pos_ff;
                     state_in = ST_PUSH_ADD;
                  end
               end else begin
                  if (req_if.seq_number < last_ack_ff ||
                      req_if.seq_number > last_push_ff) begin
                     status_in = STAT_BAD_REC;
                     state_in  = ST_RESP;
                  end else begin
                     np_in[0] = req_if.value_x;
                     np_in[1] = req_if.value_y;
                     np_in[2] = req_if.value_z;
                     state_in = (count_ff == '0) ? ST_REC_COMMIT : ST_REC_READ;
                  end
               end
            end
         end
         ST_PUSH_ADD: begin
            np_in[axis_ff] = add_res.sum;
            if (add_res.ovf) begin
               status_in = STAT_PUSH_OVF;
               state_in  = ST_RESP;
            end else if (axis_ff == LAST_AXIS) begin
               state_in = ST_PUSH_COMMIT;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         ST_PUSH_COMMIT: begin
            mem_wr_en    = 1'b1;
            pos_in       = np_ff;
            count_in     = count_ff + CNT_W'(1);
            last_push_in = seq_ff;
            status_in    = STAT_OK;
            state_in     = ST_RESP;
         end
         ST_REC_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_REC_CHECK;
         end
         ST_REC_CHECK: begin
            // Sequences in the queue increase, so the dropped entries form a prefix.
            if (mem_rd_data.seq <= seq_ff) begin
               drop_in  = drop_ff + CNT_W'(1);
               idx_in   = idx_next;
               state_in = (idx_next == count_ff) ? ST_REC_COMMIT : ST_REC_READ;
            end else begin
               axis_in  = '0;
               state_in = ST_REC_ADD;
            end
         end
         ST_REC_ADD: begin
            np_in[axis_ff] = add_res.sum;
            if (add_res.ovf) begin
               status_in = STAT_REPLAY_OVF;
               state_in  = ST_RESP;
            end else if (axis_ff == LAST_AXIS) begin
               idx_in   = idx_next;
               state_in = (idx_next == count_ff) ? ST_REC_COMMIT : ST_REC_READ;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         ST_REC_COMMIT: begin
            head_in     = wrap_slot(SUM_W'(head_ff) + SUM_W'(drop_ff));
            count_in    = count_ff - drop_ff;
            pos_in      = np_ff;
            last_ack_in = seq_ff;
            status_in   = STAT_OK;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = pos_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         last_push_ff <= '0;
         last_ack_ff  <= '0;
         pos_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_push_ff <= last_push_in;
         last_ack_ff  <= last_ack_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff         <= np_in;
      val_ff        <= val_in;
      seq_ff        <= seq_in;
      axis_ff       <= axis_in;
      idx_ff        <= idx_in;
      drop_ff       <= drop_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.pos_x         = rsp_pos_ff[0];
   assign rsp_if.pos_y         = rsp_pos_ff[1];
   assign rsp_if.pos_z         = rsp_pos_ff[2];
   assign rsp_if.pending_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_in_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue holds more entries than its depth");

   a_push_grows_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH_COMMIT |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push commit did not add one entry");

   a_read_inside_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REC_READ |-> idx_ff < count_ff && drop_ff <= idx_ff)
      else $error("replay read outside the buffered entries");

   a_rsp_from_resp_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("response beat raised outside the response state");

   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH_ADD || state_ff == ST_REC_ADD) |-> axis_ff <= LAST_AXIS)
      else $error("adder axis out of range");
`endif

endmodule

`default_nettype wire
